// ===== rtl/gvbm_pkg.sv =====
// ---------------------------------------------------------------------------
// gvbm_pkg
// shared types, fixed-point constants and series tables for the gaussian
// variate pipeline
// ---------------------------------------------------------------------------
package gvbm_pkg;

  // number formats and pipeline sizes
  localparam int LogIters    = 30;               // fraction bits of log2, one per stage
  localparam int RootW       = 27;               // radius width, Q24
  localparam int R2W         = 36;               // -2 ln u1 width, Q30
  localparam int SqShift     = 2 * RootW - R2W;  // radicand is r2 shifted up
  localparam int HornerSteps = 4;

  localparam logic [28:0] TwoLn2Q28 = 29'd372130559;
  localparam logic [31:0] TwoPiQ29  = 32'd3373259426;
  localparam logic [30:0] OneQ30    = 31'h4000_0000;

  // register indexes
  localparam logic RegMean = 1'b0;
  localparam logic RegStd  = 1'b1;

  typedef logic [31:0] side_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } cosv_t;

  typedef struct packed {
    logic [31:0] mean;
    logic [30:0] std;
  } cfg_t;

  typedef struct packed {
    logic        clipped;
    logic [31:0] sample;
  } result_t;

  // horner divisors, step 0 innermost
  function automatic logic [6:0] horner_div(input logic [1:0] step, input logic want_sin);
    logic [6:0] d;
    case ({want_sin, step})
      3'b000:  d = 7'd56;
      3'b001:  d = 7'd30;
      3'b010:  d = 7'd12;
      3'b011:  d = 7'd2;
      3'b100:  d = 7'd72;
      3'b101:  d = 7'd42;
      3'b110:  d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), quotient estimate is low by at most one
  function automatic logic [31:0] horner_recip(input logic [1:0] step, input logic want_sin);
    logic [31:0] m;
    case ({want_sin, step})
      3'b000:  m = 32'd76695844;
      3'b001:  m = 32'd143165576;
      3'b010:  m = 32'd357913941;
      3'b011:  m = 32'd2147483648;
      3'b100:  m = 32'd59652323;
      3'b101:  m = 32'd102261126;
      3'b110:  m = 32'd214748364;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/gaussian_variate_box_muller.sv =====
// ---------------------------------------------------------------------------
// gaussian_variate_box_muller
// box-muller gaussian generator, cosine branch, signed Q16.16 samples
// throughput: one sample per cycle while the skid entry is free, set by the fully
//   pipelined log squaring stages (30) and the one-bit-per-stage square root (27)
// reset: synchronous active-low rst_n empties the pipeline, mean_offset = 0,
//   std_dev = 1.0
// ---------------------------------------------------------------------------
module gaussian_variate_box_muller (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // [31:0] uniform_radius, [63:32] uniform_angle
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] sample
  output logic [0:0]  out_tuser,    // [0] clipped
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gvbm_pkg::*;

  // ---- configuration registers ----
  logic [31:0] mean_r;
  logic [30:0] std_r;
  logic        cfg_wr;
  cfg_t        cfg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= 32'd0;
      std_r  <= 31'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        RegMean: mean_r <= cfg_pwdata;
        RegStd:  std_r  <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      RegMean: cfg_prdata = mean_r;
      RegStd:  cfg_prdata = {1'b0, std_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.mean = mean_r;
  assign cfg.std  = std_r;

  // ---- output register and skid entry ----
  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_res_r, out_res_nxt;
  result_t skid_res_r, skid_res_nxt;
  logic    take;      // pipeline hands over an item this cycle
  logic    out_free;  // output register empty or being transferred

  // ---- pipeline ----
  // the whole pipeline moves together while the skid entry is free, so
  // in_tready is a register output and never waits on out_tready
  logic        en;
  logic        cos_vld, log_vld, sq_vld, pipe_vld;
  cosv_t       cos_val;
  side_t       cos_side, log_side, sq_side;
  logic [R2W-1:0]   r2;
  logic [RootW-1:0] root;
  result_t     pipe_res;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  // cosine first, radius code rides along as side payload
  gvbm_cos u_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .angle    (in_tdata[63:32]),
    .in_side  (in_tdata[31:0]),
    .out_vld  (cos_vld),
    .cosv     (cos_val),
    .out_side (cos_side)
  );

  // log term, cosine rides along
  gvbm_log u_log (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (cos_vld),
    .radius   (cos_side),
    .in_side  (side_t'(cos_val)),
    .out_vld  (log_vld),
    .r2       (r2),
    .out_side (log_side)
  );

  gvbm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (log_vld),
    .r2       (r2),
    .in_side  (log_side),
    .out_vld  (sq_vld),
    .root     (root),
    .out_side (sq_side)
  );

  gvbm_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .root    (root),
    .cosv    (cosv_t'(sq_side)),
    .cfg     (cfg),
    .out_vld (pipe_vld),
    .res     (pipe_res)
  );

  assign take     = en && pipe_vld;
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (out_free) begin
      if (skid_vld_r) begin
        // drain the parked item first
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = take;
        out_res_nxt = pipe_res;
      end
    end else if (take) begin
      // output held, park the arriving item
      skid_vld_nxt = 1'b1;
      skid_res_nxt = pipe_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_res_r.sample;
  assign out_tuser[0] = out_res_r.clipped;

  // ---- assertions ----
  // a parked item always has an older one in front of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry holds an item while the output register is empty");

  // an item arriving against a stalled output must be parked
  a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready && take) |=> skid_vld_r)
    else $error("item from the pipeline was dropped during an output stall");

  // a clipped sample sits at a range limit
  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.clipped) |->
      (out_res_r.sample == 32'h7FFF_FFFF || out_res_r.sample == 32'h8000_0000))
    else $error("clipped flag set on an unsaturated sample");

endmodule

// ===== rtl/gvbm_cos.sv =====
// ---------------------------------------------------------------------------
// gvbm_cos
// pipelined cosine of a turn fraction: quadrant fold, angle scaling and a
// four-step horner series with reciprocal division
// ---------------------------------------------------------------------------
module gvbm_cos (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [31:0]     angle,
  input  gvbm_pkg::side_t in_side,
  output logic            out_vld,
  output gvbm_pkg::cosv_t cosv,
  output gvbm_pkg::side_t out_side
);
  import gvbm_pkg::*;

  typedef struct packed {
    logic        mode;  // 1 evaluates sine
    logic        neg;
    logic [29:0] x;
    logic [29:0] x2;
    side_t       side;
  } ctx_t;

  // fold
  logic        vld0_r, mode0_r, neg0_r;
  logic [29:0] g0_r;
  side_t       side0_r;
  logic [29:0] fr;
  logic        big;

  assign fr  = angle[29:0];
  assign big = fr[29];

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else if (en) vld0_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g0_r    <= big ? (~fr + 30'd1) : fr;
      mode0_r <= angle[30] ^ big;
      neg0_r  <= angle[31] ^ angle[30];
      side0_r <= in_side;
    end
  end

  // radians
  logic        vld1_r, mode1_r, neg1_r;
  logic [29:0] x1_r;
  side_t       side1_r;
  logic [61:0] gx;

  assign gx = {32'd0, g0_r} * {30'd0, TwoPiQ29};

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else if (en) vld1_r <= vld0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= gx[60:31];
      mode1_r <= mode0_r;
      neg1_r  <= neg0_r;
      side1_r <= side0_r;
    end
  end

  // square
  logic        vld2_r;
  ctx_t        ctx2_r;
  logic [59:0] xx;

  assign xx = {30'd0, x1_r} * {30'd0, x1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else if (en) vld2_r <= vld1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r.mode <= mode1_r;
      ctx2_r.neg  <= neg1_r;
      ctx2_r.x    <= x1_r;
      ctx2_r.x2   <= xx[59:30];
      ctx2_r.side <= side1_r;
    end
  end

  // horner steps, three stages each: product, reciprocal, correction
  logic [HornerSteps-1:0] vld_a_r, vld_b_r, vld_c_r;
  ctx_t                   ctx_a_r [HornerSteps];
  ctx_t                   ctx_b_r [HornerSteps];
  ctx_t                   ctx_c_r [HornerSteps];
  logic [30:0]            y_a_r   [HornerSteps];
  logic [30:0]            y_b_r   [HornerSteps];
  logic [30:0]            q0_b_r  [HornerSteps];
  logic [30:0]            t_c_r   [HornerSteps];

  for (genvar k = 0; k < HornerSteps; k++) begin : g_step
    ctx_t        ctx_in;
    logic        vld_in;
    logic [30:0] t_in;
    logic [60:0] prod_a;
    logic [62:0] prod_b;
    logic [37:0] qd;
    logic [30:0] rem;
    logic [6:0]  div_c;

    if (k == 0) begin : g_first
      assign ctx_in = ctx2_r;
      assign vld_in = vld2_r;
      assign t_in   = OneQ30;
    end else begin : g_next
      assign ctx_in = ctx_c_r[k-1];
      assign vld_in = vld_c_r[k-1];
      assign t_in   = t_c_r[k-1];
    end

    assign prod_a = {31'd0, ctx_in.x2} * {30'd0, t_in};
    assign prod_b = {32'd0, y_a_r[k]} * {31'd0, horner_recip(2'(k), ctx_a_r[k].mode)};
    assign div_c  = horner_div(2'(k), ctx_b_r[k].mode);
    assign qd     = {7'd0, q0_b_r[k]} * {31'd0, div_c};
    assign rem    = y_b_r[k] - qd[30:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a_r[k] <= 1'b0;
        vld_b_r[k] <= 1'b0;
        vld_c_r[k] <= 1'b0;
      end else if (en) begin
        vld_a_r[k] <= vld_in;
        vld_b_r[k] <= vld_a_r[k];
        vld_c_r[k] <= vld_b_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_a_r[k] <= ctx_in;
        y_a_r[k]   <= prod_a[60:30];
        ctx_b_r[k] <= ctx_a_r[k];
        y_b_r[k]   <= y_a_r[k];
        q0_b_r[k]  <= prod_b[62:32];
        ctx_c_r[k] <= ctx_b_r[k];
        // estimate may be one short
        if (rem >= {24'd0, div_c}) t_c_r[k] <= OneQ30 - (q0_b_r[k] + 31'd1);
        else t_c_r[k] <= OneQ30 - q0_b_r[k];
      end
    end
  end

  // final: sine multiplies by x, cosine passes the series
  logic        vldf_r;
  cosv_t       cosf_r;
  side_t       sidef_r;
  logic [30:0] opnd;
  logic [61:0] prodf;

  assign opnd  = ctx_c_r[HornerSteps-1].mode ? {1'b0, ctx_c_r[HornerSteps-1].x} : OneQ30;
  assign prodf = {31'd0, opnd} * {31'd0, t_c_r[HornerSteps-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) vldf_r <= 1'b0;
    else if (en) vldf_r <= vld_c_r[HornerSteps-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cosf_r.mag <= prodf[60:30];
      cosf_r.neg <= ctx_c_r[HornerSteps-1].neg;
      sidef_r    <= ctx_c_r[HornerSteps-1].side;
    end
  end

  assign out_vld  = vldf_r;
  assign cosv     = cosf_r;
  assign out_side = sidef_r;

endmodule

// ===== rtl/gvbm_log.sv =====
// ---------------------------------------------------------------------------
// gvbm_log
// pipelined -2 ln u1: normalize, one squaring stage per log2 fraction bit,
// then scaling by 2 ln 2 in two partial products
// ---------------------------------------------------------------------------
module gvbm_log (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [31:0]             radius,
  input  gvbm_pkg::side_t         in_side,
  output logic                    out_vld,
  output logic [gvbm_pkg::R2W-1:0] r2,
  output gvbm_pkg::side_t         out_side
);
  import gvbm_pkg::*;

  // m = k + 1
  logic        vld0_r;
  logic [32:0] m0_r;
  side_t       side0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else if (en) vld0_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r    <= {1'b0, radius} + 33'd1;
      side0_r <= in_side;
    end
  end

  // coarse normalize
  logic        vld1_r, top1_r;
  logic [31:0] v1_r;
  logic [1:0]  sh1_r;
  side_t       side1_r;
  logic        s16, s8;
  logic [31:0] u1, u2;

  assign s16 = (m0_r[31:16] == 16'd0);
  assign u1  = s16 ? {m0_r[15:0], 16'd0} : m0_r[31:0];
  assign s8  = (u1[31:24] == 8'd0);
  assign u2  = s8 ? {u1[23:0], 8'd0} : u1;

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else if (en) vld1_r <= vld0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r    <= u2;
      sh1_r   <= {s16, s8};
      top1_r  <= m0_r[32];
      side1_r <= side0_r;
    end
  end

  // fine normalize, integer part of -log2
  logic        vld2_r;
  logic [31:0] xn_r;
  logic [5:0]  ip2_r;
  side_t       side2_r;
  logic        s4, s2, s1;
  logic [31:0] w1, w2, w3;

  assign s4 = (v1_r[31:28] == 4'd0);
  assign w1 = s4 ? {v1_r[27:0], 4'd0} : v1_r;
  assign s2 = (w1[31:30] == 2'd0);
  assign w2 = s2 ? {w1[29:0], 2'd0} : w1;
  assign s1 = !w2[31];
  assign w3 = s1 ? {w2[30:0], 1'b0} : w2;

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else if (en) vld2_r <= vld1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // u1 of exactly one: log term is zero
      xn_r    <= top1_r ? 32'h8000_0000 : w3;
      ip2_r   <= top1_r ? 6'd0 : ({1'b0, sh1_r, s4, s2, s1} + 6'd1);
      side2_r <= side1_r;
    end
  end

  // squaring stages
  logic [LogIters-1:0] vld_i_r;
  logic [31:0]         x_i_r  [LogIters];
  logic [LogIters-1:0] f_i_r  [LogIters];
  logic [5:0]          ip_i_r [LogIters];
  side_t               side_i_r [LogIters];

  for (genvar k = 0; k < LogIters; k++) begin : g_sq
    logic                vld_in;
    logic [31:0]         x_in;
    logic [LogIters-1:0] f_in;
    logic [5:0]          ip_in;
    side_t               side_in;
    logic [63:0]         sq;
    logic [32:0]         y;

    if (k == 0) begin : g_first
      assign vld_in  = vld2_r;
      assign x_in    = xn_r;
      assign f_in    = '0;
      assign ip_in   = ip2_r;
      assign side_in = side2_r;
    end else begin : g_next
      assign vld_in  = vld_i_r[k-1];
      assign x_in    = x_i_r[k-1];
      assign f_in    = f_i_r[k-1];
      assign ip_in   = ip_i_r[k-1];
      assign side_in = side_i_r[k-1];
    end

    assign sq = {32'd0, x_in} * {32'd0, x_in};
    assign y  = sq[63:31];

    always_ff @(posedge clk) begin
      if (!rst_n) vld_i_r[k] <= 1'b0;
      else if (en) vld_i_r[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_i_r[k]    <= y[32] ? y[32:1] : y[31:0];
        f_i_r[k]    <= {f_in[LogIters-2:0], y[32]};
        ip_i_r[k]   <= ip_in;
        side_i_r[k] <= side_in;
      end
    end
  end

  // t = -log2 u1 in Q30
  logic           vldt_r, vldp_r, vldr_r;
  logic [R2W-1:0] t_r;
  logic [46:0]    pph_r, ppl_r;
  logic [R2W-1:0] r2_r;
  side_t          sidet_r, sidep_r, sider_r;
  logic [64:0]    psum;

  assign psum = {pph_r, 18'd0} + {18'd0, ppl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldt_r <= 1'b0;
      vldp_r <= 1'b0;
      vldr_r <= 1'b0;
    end else if (en) begin
      vldt_r <= vld_i_r[LogIters-1];
      vldp_r <= vldt_r;
      vldr_r <= vldp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= {ip_i_r[LogIters-1], 30'd0} - {6'd0, f_i_r[LogIters-1]};
      sidet_r <= side_i_r[LogIters-1];
      pph_r   <= {29'd0, t_r[35:18]} * {18'd0, TwoLn2Q28};
      ppl_r   <= {29'd0, t_r[17:0]} * {18'd0, TwoLn2Q28};
      sidep_r <= sidet_r;
      r2_r    <= psum[63:28];
      sider_r <= sidep_r;
    end
  end

  assign out_vld  = vldr_r;
  assign r2       = r2_r;
  assign out_side = sider_r;

endmodule

// ===== rtl/gvbm_sqrt.sv =====
// ---------------------------------------------------------------------------
// gvbm_sqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module gvbm_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [gvbm_pkg::R2W-1:0]  r2,
  input  gvbm_pkg::side_t           in_side,
  output logic                      out_vld,
  output logic [gvbm_pkg::RootW-1:0] root,
  output gvbm_pkg::side_t           out_side
);
  import gvbm_pkg::*;

  logic           vld0_r;
  logic [R2W-1:0] r2_0_r;
  side_t          side0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else if (en) vld0_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_0_r  <= r2;
      side0_r <= in_side;
    end
  end

  logic [RootW-1:0] vld_s_r;
  logic [RootW+1:0] rem_s_r  [RootW];
  logic [RootW-1:0] root_s_r [RootW];
  logic [R2W-1:0]   r2_s_r   [RootW];
  side_t            side_s_r [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_bit
    localparam int P = RootW - 1 - j;  // bit pair taken down here
    logic               vld_in;
    logic [RootW+1:0]   rem_in;
    logic [RootW-1:0]   root_in;
    logic [R2W-1:0]     r2_in;
    side_t              side_in;
    logic [2*RootW-1:0] vbits;
    logic [RootW+3:0]   rr, trial, diff;
    logic               ge;

    if (j == 0) begin : g_first
      assign vld_in  = vld0_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign r2_in   = r2_0_r;
      assign side_in = side0_r;
    end else begin : g_next
      assign vld_in  = vld_s_r[j-1];
      assign rem_in  = rem_s_r[j-1];
      assign root_in = root_s_r[j-1];
      assign r2_in   = r2_s_r[j-1];
      assign side_in = side_s_r[j-1];
    end

    assign vbits = {r2_in, {SqShift{1'b0}}};
    assign rr    = {rem_in, vbits[2*P+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (rr >= trial);
    assign diff  = rr - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) vld_s_r[j] <= 1'b0;
      else if (en) vld_s_r[j] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s_r[j]  <= ge ? diff[RootW+1:0] : rr[RootW+1:0];
        root_s_r[j] <= {root_in[RootW-2:0], ge};
        r2_s_r[j]   <= r2_in;
        side_s_r[j] <= side_in;
      end
    end
  end

  assign out_vld  = vld_s_r[RootW-1];
  assign root     = root_s_r[RootW-1];
  assign out_side = side_s_r[RootW-1];

endmodule

// ===== rtl/gvbm_scale.sv =====
// ---------------------------------------------------------------------------
// gvbm_scale
// radius times cosine, deviation scaling with rounding, mean offset and
// saturation
// ---------------------------------------------------------------------------
module gvbm_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [gvbm_pkg::RootW-1:0] root,
  input  gvbm_pkg::cosv_t           cosv,
  input  gvbm_pkg::cfg_t            cfg,
  output logic                      out_vld,
  output gvbm_pkg::result_t         res
);
  import gvbm_pkg::*;

  logic             vld0_r, vld1_r, vld2_r;
  logic [RootW-1:0] z_r;
  logic             neg0_r, neg1_r;
  logic [57:0]      p_r;
  result_t          res_r;
  logic [57:0]      zp, sp;
  logic [58:0]      rnd;
  logic [34:0]      mag;
  logic signed [36:0] mean_x, mag_x, sum;
  logic             hi, lo;

  assign zp     = {31'd0, root} * {27'd0, cosv.mag};
  assign sp     = {31'd0, z_r} * {27'd0, cfg.std};
  assign rnd    = {1'b0, p_r} + 59'h80_0000;
  assign mag    = rnd[58:24];
  assign mean_x = {{5{cfg.mean[31]}}, cfg.mean};
  assign mag_x  = {2'b00, mag};
  assign sum    = neg1_r ? (mean_x - mag_x) : (mean_x + mag_x);
  assign hi     = (sum > 37'sh0_7FFF_FFFF);
  assign lo     = (sum < -37'sh0_8000_0000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_vld;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r    <= zp[56:30];
      neg0_r <= cosv.neg;
      p_r    <= sp;
      neg1_r <= neg0_r;
      res_r.clipped <= hi || lo;
      if (hi) res_r.sample <= 32'h7FFF_FFFF;
      else if (lo) res_r.sample <= 32'h8000_0000;
      else res_r.sample <= sum[31:0];
    end
  end

  assign out_vld = vld2_r;
  assign res     = res_r;

endmodule

// ===== sim/gaussian_variate_checker.sv =====
// ---------------------------------------------------------------------------
// gaussian_variate_checker
// watches both streams of the box-muller generator, predicts every sample
// from the uniform codes and the current register values, and compares
// ---------------------------------------------------------------------------
module gaussian_variate_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_count
);
  import gvbm_pkg::*;

  logic [31:0] mean_q;
  logic [30:0] std_q;
  result_t     sample_queue[$];

  assign pending_count = sample_queue.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] minus_two_ln(input logic [31:0] k);
    logic [63:0] m, x, f, t;
    int p;
    m = {32'd0, k} + 64'd1;
    p = 0;
    f = 0;
    while (p < 32 && (m >> (p + 1)) != 0) p++;
    x = (p <= 31) ? (m << (31 - p)) : (m >> 1);
    for (int i = 0; i < 30; i++) begin
      x = (x * x) >> 31;
      f = f << 1;
      if (x >= (64'd1 << 32)) begin
        x = x >> 1;
        f = f | 64'd1;
      end
    end
    t = (64'(32 - p) << 30) - f;
    return (t * 64'(TwoLn2Q28)) >> 28;
  endfunction

  function automatic logic [63:0] trig_series(input logic [63:0] g, input logic want_sin);
    logic [63:0] x, x2, t, one;
    one = 64'd1 << 30;
    x = (g * 64'(TwoPiQ29)) >> 31;
    x2 = (x * x) >> 30;
    if (want_sin) begin
      t = one - x2 / 72;
      t = one - ((x2 * t) >> 30) / 42;
      t = one - ((x2 * t) >> 30) / 20;
      t = one - ((x2 * t) >> 30) / 6;
      return (x * t) >> 30;
    end
    t = one - x2 / 56;
    t = one - ((x2 * t) >> 30) / 30;
    t = one - ((x2 * t) >> 30) / 12;
    return one - ((x2 * t) >> 30) / 2;
  endfunction

  function automatic result_t predict_sample(input logic [31:0] ur, input logic [31:0] ua);
    logic [63:0] r, c, z, mag, f;
    logic [1:0]  q;
    logic        use_sin, neg;
    longint      sum;
    result_t     res;
    r = int_sqrt(minus_two_ln(ur) << 18);
    q = ua[31:30];
    f = {34'd0, ua[29:0]};
    use_sin = q[0];
    neg = (q == 2'd1) || (q == 2'd2);
    if (f < (64'd1 << 29)) c = trig_series(f, use_sin);
    else c = trig_series((64'd1 << 30) - f, !use_sin);
    z = (r * c) >> 30;
    mag = (z * 64'(std_q) + (64'd1 << 23)) >> 24;
    sum = neg ? longint'($signed(mean_q)) - longint'(mag)
              : longint'($signed(mean_q)) + longint'(mag);
    res.clipped = 1'b0;
    if (sum > 64'sh7FFF_FFFF) begin
      sum = 64'sh7FFF_FFFF;
      res.clipped = 1'b1;
    end else if (sum < -64'sh8000_0000) begin
      sum = -64'sh8000_0000;
      res.clipped = 1'b1;
    end
    res.sample = sum[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mean_q <= 32'd0;
      std_q <= 31'd65536;
      fail_count <= 0;
      sample_queue.delete();
    end else begin
      // registers must only change while idle (the generator does not enforce this), so prediction at the input is safe
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == RegMean) mean_q <= cfg_pwdata;
        else std_q <= cfg_pwdata[30:0];
      end
      if (in_tvalid && in_tready)
        sample_queue.insert(sample_queue.size(),
                            predict_sample(in_tdata[31:0], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        if (sample_queue.size() == 0) begin
          $display("%0t: unexpected sample %h clipped %b", $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          result_t want;
          want = sample_queue.pop_front();
          if (want.sample !== out_tdata || want.clipped !== out_tuser[0]) begin
            $display("%0t: expected sample %h clipped %b, got %h clipped %b",
                     $time, want.sample, want.clipped, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/gaussian_variate_box_muller_test.sv =====
// ---------------------------------------------------------------------------
// gaussian_variate_box_muller_test
// drives uniform code pairs and register writes into the generator with
// random gaps on both streams; the checker predicts and compares samples
// ---------------------------------------------------------------------------
module gaussian_variate_box_muller_test;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [63:0] in_tdata;             // [31:0] uniform_radius, [63:32] uniform_angle
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;            // [31:0] sample
  logic [0:0]  out_tuser;            // [0] clipped
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending_count;

  localparam logic [2:0] AddrMean = 3'd0;
  localparam logic [2:0] AddrStd  = 3'd4;
  localparam int         DrainCycles = 120;   // idle wait after the checker queue empties

  gaussian_variate_box_muller DUT (.*);

  gaussian_variate_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // short gap most of the time, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls at random, with long stretches of no stall
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 9) < 3) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 40)) @(posedge clk);
    end
  end

  // one transfer; valid stays high straight into the next item when no gap
  task automatic send_pair(input logic [31:0] radius, input logic [31:0] angle);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {angle, radius};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // random codes, biased toward edges of the radius range
  function automatic logic [31:0] rand_radius();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 255);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    logic [31:0] a;
    a = $urandom;
    // sometimes land right on a quadrant or octant boundary
    if ($urandom_range(0, 7) == 0) a[28:0] = $urandom_range(0, 1) ? 29'd0 : 29'h1FFF_FFFF;
    return a;
  endfunction

  logic [31:0] mean_set[6] = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFF0_0000,
                               32'h0010_0000, 32'd0};
  logic [31:0] std_set[6]  = '{32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0,
                               32'hFFFF_FFFF, 32'd65536};

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: radius extremes (largest code gives mean only), quadrant edges
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h4000_0000);
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h0000_0000, 32'hC000_0000);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'h0000_0000, 32'h2000_0000);
    send_pair(32'h0000_0000, 32'h1FFF_FFFF);
    send_pair(32'hFFFF_FFFE, 32'h6000_0000);
    send_pair(32'h8000_0000, 32'hA000_0000);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    drain();
    // saturation both ways, unaligned register address
    reg_write(AddrStd, 32'h7FFF_FFFF);
    reg_write(3'd3, 32'h1234_5678);
    reg_write(AddrMean, 32'h7FFF_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h8000_0000);
    drain();
    reg_write(AddrMean, 32'h8000_0000);
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h8000_0000);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(AddrMean, (ph == 5) ? $urandom : mean_set[ph]);
      reg_write(AddrStd, (ph == 5) ? $urandom : std_set[ph]);
      for (int n = 0; n < 315; n++) begin
        send_pair(rand_radius(), rand_angle());
        // hold the sender until the pipeline has emptied
        if (n == 150) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
